// File: hdl/crc32ab_pkg.sv
// Package: CRC-32 constants and the byte-step functions for the augmented CRC engine.
`timescale 1ns / 1ps

package crc32ab_pkg;

  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_TOP_BIT = 32'h8000_0000;
  localparam int          TOP_SHIFT   = 24;
  localparam logic [2:0]  SEEN_FULL   = 3'd4;

  function automatic logic [31:0] table_word(input logic [7:0] idx);
    logic [31:0] w;
    w = {idx, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if ((w & CRC_TOP_BIT) != 32'h0) begin
        w = {w[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        w = {w[30:0], 1'b0};
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] shift_byte(input logic [31:0] r, input logic [7:0] b);
    return {r[23:0], b} ^ table_word(r[31:TOP_SHIFT]);
  endfunction

endpackage

// File: hdl/crc32_augmented_byte_engine_unit.sv
// Top level: input register, CRC update stage and result register.
`timescale 1ns / 1ps

// Non-reflected CRC-32 (poly 0x04C11DB7), augmented-message form, one byte per
// request. A request is taken every cycle unless a stalled result blocks it;
// an is_last request passes the input register, then its result is loaded into
// the result register and held there until taken. The byte update (with the
// four-byte append) is combinational, between the input and result registers.
// While a result waits, one more request is held in the input register.
module crc32_augmented_byte_engine_unit
  import crc32ab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        append_mode,
  input  logic [31:0] append_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] crc_value
);

  logic        s1_valid;
  logic        s1_has_byte;
  logic [7:0]  s1_data_byte;
  logic        s1_is_last;
  logic        s1_append_mode;
  logic [31:0] s1_append_value;

  logic [31:0] acc;
  logic [2:0]  seen;
  logic [31:0] acc_next;
  logic [2:0]  seen_next;
  logic [31:0] result;
  logic        advance;
  logic        fire;

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  crc32ab_core u_core (
    .acc          (acc),
    .seen         (seen),
    .has_byte     (s1_has_byte),
    .data_byte    (s1_data_byte),
    .is_last      (s1_is_last),
    .append_mode  (s1_append_mode),
    .append_value (s1_append_value),
    .acc_next     (acc_next),
    .seen_next    (seen_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= 32'h0;
      seen      <= 3'd0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (fire) begin
        acc  <= acc_next;
        seen <= seen_next;
      end
      if (fire && s1_is_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_has_byte     <= has_byte;
      s1_data_byte    <= data_byte;
      s1_is_last      <= is_last;
      s1_append_mode  <= append_mode;
      s1_append_value <= append_value;
    end
    if (fire && s1_is_last) begin
      crc_value <= result;
    end
  end

endmodule

// File: hdl/crc32ab_core.sv
// Byte update of the accumulator, final word selection and four-byte append.
`timescale 1ns / 1ps

module crc32ab_core
  import crc32ab_pkg::*;
(
  input  logic [31:0] acc,
  input  logic [2:0]  seen,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        append_mode,
  input  logic [31:0] append_value,
  output logic [31:0] acc_next,
  output logic [2:0]  seen_next,
  output logic [31:0] result
);

  logic [31:0] acc_msg;
  logic [2:0]  seen_msg;
  logic [31:0] packed_word;
  logic [31:0] final_word;
  logic [31:0] appended;

  always_comb begin
    case (seen)
      3'd0:    packed_word = acc | {data_byte, 24'h0};
      3'd1:    packed_word = acc | {8'h0, data_byte, 16'h0};
      3'd2:    packed_word = acc | {16'h0, data_byte, 8'h0};
      3'd3:    packed_word = ~(acc | {24'h0, data_byte});
      default: packed_word = shift_byte(acc, data_byte);
    endcase
  end

  always_comb begin
    if (has_byte) begin
      acc_msg  = packed_word;
      seen_msg = (seen == SEEN_FULL) ? SEEN_FULL : seen + 3'd1;
    end else begin
      acc_msg  = acc;
      seen_msg = seen;
    end
  end

  assign final_word = (seen_msg == SEEN_FULL) ? ~acc_msg : acc_msg;

  // append word goes in least significant byte first
  assign appended = ~shift_byte(shift_byte(shift_byte(shift_byte(final_word,
                      append_value[7:0]), append_value[15:8]),
                      append_value[23:16]), append_value[31:24]);

  assign result    = append_mode ? appended : final_word;
  assign acc_next  = is_last ? 32'h0 : acc_msg;
  assign seen_next = is_last ? 3'd0 : seen_msg;

endmodule

// File: hdl/crc32ab_checker.sv
// Port-level checker for the CRC engine, bound to the top level.
`timescale 1ns / 1ps

module crc32ab_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] crc_value
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("stalled result changed");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request stalled without a blocked result");

  a_drop_only_when_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule

bind crc32_augmented_byte_engine_unit crc32ab_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .crc_value (crc_value)
);

// File: tb/sv/tb_top.sv
// Testbench for the augmented CRC-32 byte engine: random bursts, stalls, result checks.
`timescale 1ns / 1ps

module tb_top;
  import crc32ab_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_REQS   = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 40;
  localparam int END_SETTLE  = 10;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_t;

  typedef struct {
    logic        hb;
    logic [7:0]  db;
    logic        last;
    logic        amode;
    logic [31:0] aval;
    bit          drain;
  } crc_req_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        has_byte     = 1'b0;
  logic [7:0]  data_byte    = 8'h00;
  logic        is_last      = 1'b0;
  logic        append_mode  = 1'b0;
  logic [31:0] append_value = 32'h0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] crc_value;

  crc_req_t    req_q[$];
  logic [31:0] crc_expect_q[$];
  crc_req_t    cur_req;

  logic [31:0] acc_state = 32'h0;
  logic [2:0]  seen_cnt  = 3'd0;

  int          burst_left   = 0;
  int          gap_left     = 0;
  int          err_cnt      = 0;
  int          results_seen = 0;
  int          cycle_cnt    = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;
  int          phase_left   = 0;
  rx_style_t   rx_style     = RX_OPEN;
  bit          drain_next   = 1'b0;

  crc32_augmented_byte_engine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .has_byte     (has_byte),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .append_mode  (append_mode),
    .append_value (append_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .crc_value    (crc_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] crc_fold_term(input logic [7:0] top);
    logic [31:0] w;
    w = {top, 24'h0};
    repeat (8) begin
      w = w[31] ? ({w[30:0], 1'b0} ^ CRC_POLY) : {w[30:0], 1'b0};
    end
    return w;
  endfunction

  function automatic logic [31:0] crc_push_byte(input logic [31:0] r, input logic [7:0] b);
    return {r[23:0], b} ^ crc_fold_term(r[31:24]);
  endfunction

  task automatic predict_request();
    logic [31:0] r;
    if (has_byte) begin
      if (seen_cnt < SEEN_FULL) begin
        acc_state = acc_state | ({24'h0, data_byte} << (24 - 8 * int'(seen_cnt)));
        seen_cnt  = seen_cnt + 3'd1;
        if (seen_cnt == SEEN_FULL) begin
          acc_state = ~acc_state;
        end
      end else begin
        acc_state = crc_push_byte(acc_state, data_byte);
      end
    end
    if (is_last) begin
      r = (seen_cnt >= SEEN_FULL) ? ~acc_state : acc_state;
      if (append_mode) begin
        for (int k = 0; k < 4; k++) begin
          r = crc_push_byte(r, append_value[8*k +: 8]);
        end
        r = ~r;
      end
      crc_expect_q.push_back(r);
      acc_state = 32'h0;
      seen_cnt  = 3'd0;
    end
  endtask

  task automatic add_req(input logic hb, input logic [7:0] db, input logic last,
                         input logic amode, input logic [31:0] aval);
    crc_req_t r;
    r.hb    = hb;
    r.db    = db;
    r.last  = last;
    r.amode = amode;
    r.aval  = aval;
    r.drain = drain_next;
    drain_next = 1'b0;
    req_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request();
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0 || (req_q[0].drain && crc_expect_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          has_byte     <= cur_req.hb;
          data_byte    <= cur_req.db;
          is_last      <= cur_req.last;
          append_mode  <= cur_req.amode;
          append_value <= cur_req.aval;
          in_valid     <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_style   <= rx_style_t'($urandom_range(0, 3));
        phase_left <= $urandom_range(20, 80);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (crc_expect_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %08h", $time, crc_value);
        err_cnt = err_cnt + 1;
      end else if (crc_expect_q[0] !== crc_value) begin
        $display("%0t crc_value mismatch: expected %08h actual %08h",
                 $time, crc_expect_q[0], crc_value);
        err_cnt = err_cnt + 1;
        void'(crc_expect_q.pop_front());
      end else begin
        void'(crc_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int   counted;
    int   msg_len;
    bit   no_byte_end;
    logic amode;

    counted = 0;

    add_req(1'b0, 8'h00, 1'b1, 1'b0, 32'h0000_0000);
    add_req(1'b0, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_req(1'b0, 8'hA5, 1'b0, 1'b1, 32'h1234_5678);
    add_req(1'b1, 8'h00, 1'b1, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b1, 1'b1, 32'h0000_0000);
    add_req(1'b1, 8'h80, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h01, 1'b1, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h00, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b1, 1'b1, 32'h5A5A_5A5A);
    add_req(1'b1, 8'h12, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h34, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h56, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h78, 1'b1, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    add_req(1'b1, 8'hFF, 1'b0, 1'b1, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b0, 8'h3C, 1'b0, 1'b1, 32'hA5A5_A5A5);
    add_req(1'b1, 8'hFF, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_req(1'b1, 8'h01, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h02, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b1, 8'h03, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b0, 8'h00, 1'b1, 1'b1, 32'h8000_0001);
    add_req(1'b1, 8'h7F, 1'b0, 1'b0, 32'h0000_0000);
    add_req(1'b0, 8'hFF, 1'b1, 1'b0, 32'h0000_0000);

    while (counted < RAND_REQS) begin
      msg_len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      no_byte_end = (msg_len == 0) || ($urandom_range(0, 4) == 0);
      if (counted >= RAND_REQS / 2 && counted < RAND_REQS / 2 + 60) begin
        drain_next = 1'b1;
      end
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_req(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                  $urandom());
          counted++;
        end
        amode = 1'($urandom_range(0, 1));
        add_req(1'b1, 8'($urandom_range(0, 255)), (k == msg_len - 1) && !no_byte_end,
                amode, $urandom());
        counted++;
      end
      if (no_byte_end) begin
        amode = 1'($urandom_range(0, 1));
        add_req(1'b0, 8'($urandom_range(0, 255)), 1'b1, amode, $urandom());
        counted++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || in_valid) @(negedge clk);
    while (crc_expect_q.size() != 0) @(negedge clk);
    repeat (END_SETTLE) @(negedge clk);

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/crc32ab_pkg.sv
hdl/crc32ab_core.sv
hdl/crc32_augmented_byte_engine_unit.sv
hdl/crc32ab_checker.sv
tb/sv/tb_top.sv
